[rtl/core/sync_len_sum_frame_receiver_top_defines.svh]
// ----------------------------------------------------------------------------
// sync_len_sum_frame_receiver_top_defines
// assertion macros shared by the frame receiver rtl
// ----------------------------------------------------------------------------
`ifndef SYNC_LEN_SUM_FRAME_RECEIVER_TOP_DEFINES_SVH
`define SYNC_LEN_SUM_FRAME_RECEIVER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SLFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("slfr assertion failed");

// next-cycle implication
`define SLFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("slfr assertion failed");

`else

`define SLFR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SLFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/slfr_pkg.sv]
// ----------------------------------------------------------------------------
// slfr_pkg
// types and codes shared by the frame receiver modules
// ----------------------------------------------------------------------------
package slfr_pkg;

	localparam int ByteW = 8;
	localparam int IdW   = 16;

	// configuration register indexes
	localparam logic [1:0] CFG_SYNC_BYTE   = 2'd0;
	localparam logic [1:0] CFG_ID_LIMIT    = 2'd1;
	localparam logic [1:0] CFG_TWO_BYTE_ID = 2'd2;

	localparam logic [ByteW-1:0] SYNC_BYTE_RST = 8'd170;
	localparam logic [ByteW-1:0] ID_LIMIT_RST  = 8'd255;

	typedef enum logic [2:0] {
		ST_HEADER  = 3'd0,
		ST_PAYLOAD = 3'd1,
		ST_GOOD    = 3'd2,
		ST_BADSUM  = 3'd3,
		ST_REJECT  = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		PH_HUNT  = 5'b00001,
		PH_ID    = 5'b00010,
		PH_LEN   = 5'b00100,
		PH_DATA  = 5'b01000,
		PH_CHECK = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [ByteW-1:0] sync_byte;
		logic [ByteW-1:0] id_limit;
		logic             two_byte_id;
	} cfg_t;

	typedef struct packed {
		status_t          status;
		logic [ByteW-1:0] payload_byte;
		logic [ByteW-1:0] payload_index;
		logic [IdW-1:0]   frame_id;
		logic [ByteW-1:0] frame_length;
	} result_t;

endpackage

[rtl/core/sync_len_sum_frame_receiver_top.sv]
// ----------------------------------------------------------------------------
// sync_len_sum_frame_receiver_top
// sync / id / length / checksum frame receiver, one status result per byte
// ----------------------------------------------------------------------------
//
// channel   dir  fields
// s_*       in   tdata[7:0] rx_byte
// m_*       out  tuser[2:0] status; tdata: payload_byte, payload_index,
//                frame_id, frame_length
// cfg_*     in   index 0 sync_byte, 1 id_limit, 2 two_byte_id
//
// one byte per cycle while the result register is not stalled; the result
// shows in the cycle after the request is taken, set by the result register
// arst_n puts the parser into sync hunt and loads the register defaults
// a stalled result holds in the result register; a new request is taken in
// the same cycle the held one drains
//
`include "sync_len_sum_frame_receiver_top_defines.svh"

module sync_len_sum_frame_receiver_top
	import slfr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// input stream
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] rx_byte
	// output stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [2:0]       m_tuser,   // [2:0] status
	output logic [39:0]      m_tdata,   // [7:0] payload_byte, [15:8] payload_index,
	                                    // [31:16] frame_id, [39:32] frame_length
	// configuration writes
	input  logic             cfg_wr_en,
	input  logic [1:0]       cfg_index,
	input  logic [ByteW-1:0] cfg_data
);

	cfg_t    cfg_q;
	result_t parse_res;
	result_t out_res;
	logic    take;

	// configuration registers, write only, index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_byte   <= SYNC_BYTE_RST;
			cfg_q.id_limit    <= ID_LIMIT_RST;
			cfg_q.two_byte_id <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_SYNC_BYTE:   cfg_q.sync_byte   <= cfg_data;
				CFG_ID_LIMIT:    cfg_q.id_limit    <= cfg_data;
				CFG_TWO_BYTE_ID: cfg_q.two_byte_id <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// a request advances the frame state only when the result register takes it
	assign take = s_tvalid && s_tready;

	slfr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (s_tdata),
		.cfg     (cfg_q),
		.res     (parse_res)
	);

	slfr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_res    (parse_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// result packing, status travels as the sideband kind
	assign m_tuser = out_res.status;
	assign m_tdata = {out_res.frame_length, out_res.frame_id,
		out_res.payload_index, out_res.payload_byte};

endmodule

[rtl/core/slfr_parser.sv]
// ----------------------------------------------------------------------------
// slfr_parser
// frame state and per-byte next-state / status logic
// ----------------------------------------------------------------------------
`include "sync_len_sum_frame_receiver_top_defines.svh"

module slfr_parser
	import slfr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [ByteW-1:0] rx_byte,
	input  cfg_t             cfg,
	output result_t          res
);

	phase_t           phase_q, phase_d;
	logic [ByteW-1:0] sum_q, sum_d;
	logic [IdW-1:0]   id_q, id_d;
	logic [ByteW-1:0] len_q, len_d;
	logic [ByteW-1:0] seen_q, seen_d;
	logic             hi_next_q, hi_next_d;
	logic [ByteW-1:0] seen_inc;
	logic [ByteW-1:0] sum_add;

	assign seen_inc = seen_q + 8'd1;
	assign sum_add  = sum_q + rx_byte;

	always_comb begin
		phase_d           = phase_q;
		sum_d             = sum_q;
		id_d              = id_q;
		len_d             = len_q;
		seen_d            = seen_q;
		hi_next_d         = hi_next_q;
		res.status        = ST_HEADER;
		res.payload_byte  = '0;
		res.payload_index = '0;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte == cfg.sync_byte) begin
					sum_d     = rx_byte;
					id_d      = '0;
					len_d     = '0;
					seen_d    = '0;
					hi_next_d = 1'b0;
					phase_d   = PH_ID;
				end
			end
			PH_ID: begin
				if (cfg.two_byte_id) begin
					sum_d = sum_add;
					if (!hi_next_q) begin
						id_d      = {8'd0, rx_byte};
						hi_next_d = 1'b1;
					end else begin
						id_d      = {rx_byte, id_q[ByteW-1:0]};
						hi_next_d = 1'b0;
						phase_d   = PH_LEN;
					end
				end else begin
					hi_next_d = 1'b0;
					id_d      = {8'd0, rx_byte};
					if (rx_byte < cfg.id_limit) begin
						sum_d   = sum_add;
						phase_d = PH_LEN;
					end else begin
						res.status = ST_REJECT;
						phase_d    = PH_HUNT;
					end
				end
			end
			PH_LEN: begin
				len_d   = rx_byte;
				sum_d   = sum_add;
				seen_d  = '0;
				phase_d = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
			end
			PH_DATA: begin
				res.status        = ST_PAYLOAD;
				res.payload_byte  = rx_byte;
				res.payload_index = seen_q;
				sum_d             = sum_add;
				seen_d            = seen_inc;
				if (seen_inc >= len_q) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				res.status = (sum_q == rx_byte) ? ST_GOOD : ST_BADSUM;
				phase_d    = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
		res.frame_id     = id_d;
		res.frame_length = len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			sum_q     <= '0;
			id_q      <= '0;
			len_q     <= '0;
			seen_q    <= '0;
			hi_next_q <= 1'b0;
		end else if (take) begin
			phase_q   <= phase_d;
			sum_q     <= sum_d;
			id_q      <= id_d;
			len_q     <= len_d;
			seen_q    <= seen_d;
			hi_next_q <= hi_next_d;
		end
	end

	// a frame end or a rejected id always drops back to hunting
	`SLFR_ASSERT_NEXT(a_end_hunt, clk, arst_n,
		take && (res.status == ST_REJECT || res.status == ST_GOOD ||
		res.status == ST_BADSUM), phase_q == PH_HUNT)
	// payload count stays below the declared length while in the data phase
	`SLFR_ASSERT_IMPL(a_data_count, clk, arst_n, phase_q == PH_DATA, seen_q < len_q)
	// payload fields are zero outside payload results
	`SLFR_ASSERT_IMPL(a_payload_zero, clk, arst_n, res.status != ST_PAYLOAD,
		res.payload_byte == 8'd0 && res.payload_index == 8'd0)

endmodule

[rtl/core/slfr_out_reg.sv]
// ----------------------------------------------------------------------------
// slfr_out_reg
// result register between the parser and the output stream
// ----------------------------------------------------------------------------
`include "sync_len_sum_frame_receiver_top_defines.svh"

module slfr_out_reg
	import slfr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  result_t in_res,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic    valid_q;
	result_t res_q;

	// register can refill in the same cycle it is drained
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_q <= in_res;
		end
	end

	// a held result is never overwritten
	`SLFR_ASSERT_NEXT(a_no_overwrite, clk, arst_n, valid_q && !out_ready,
		valid_q && res_q == $past(res_q))

endmodule

[verif/sync_len_sum_frame_receiver_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_len_sum_frame_receiver_checker
// tracks the parser state from accepted bytes and config writes, predicts one
// status result per byte and compares each result request field by field
// ----------------------------------------------------------------------------
module sync_len_sum_frame_receiver_checker
	import slfr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] rx_byte
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [2:0]       m_tuser,   // [2:0] status
	input  logic [39:0]      m_tdata,   // [7:0] payload_byte, [15:8] payload_index,
	                                    // [31:16] frame_id, [39:32] frame_length
	input  logic             cfg_wr_en,
	input  logic [1:0]       cfg_index,
	input  logic [ByteW-1:0] cfg_data,
	output int               fail_count,
	output int               pending_count
);

	cfg_t             cfg_shadow;
	phase_t           parse_phase;
	logic [ByteW-1:0] frame_sum;
	logic [IdW-1:0]   id_acc;
	logic [ByteW-1:0] len_acc;
	logic [ByteW-1:0] payload_count;
	logic             id_high_due;
	result_t          expected_status_q[$];

	initial fail_count = 0;

	// one parser step for a received byte
	task automatic advance_parser(input logic [ByteW-1:0] b, output result_t r);
		r = '0;
		r.status = ST_HEADER;
		case (parse_phase)
			PH_HUNT: begin
				if (b == cfg_shadow.sync_byte) begin
					frame_sum     = b;
					id_acc        = '0;
					len_acc       = '0;
					payload_count = '0;
					id_high_due   = 1'b0;
					parse_phase   = PH_ID;
				end
			end
			PH_ID: begin
				if (cfg_shadow.two_byte_id) begin
					frame_sum = frame_sum + b;
					if (!id_high_due) begin
						id_acc      = {8'h00, b};
						id_high_due = 1'b1;
					end else begin
						id_acc      = {b, id_acc[7:0]};
						id_high_due = 1'b0;
						parse_phase = PH_LEN;
					end
				end else begin
					// a pending high id byte is dropped in one-byte mode
					id_high_due = 1'b0;
					id_acc      = {8'h00, b};
					if (b < cfg_shadow.id_limit) begin
						frame_sum   = frame_sum + b;
						parse_phase = PH_LEN;
					end else begin
						r.status    = ST_REJECT;
						parse_phase = PH_HUNT;
					end
				end
			end
			PH_LEN: begin
				len_acc       = b;
				frame_sum     = frame_sum + b;
				payload_count = '0;
				parse_phase   = (b == 8'd0) ? PH_CHECK : PH_DATA;
			end
			PH_DATA: begin
				r.status        = ST_PAYLOAD;
				r.payload_byte  = b;
				r.payload_index = payload_count;
				frame_sum       = frame_sum + b;
				payload_count   = payload_count + 8'd1;
				if (payload_count >= len_acc)
					parse_phase = PH_CHECK;
			end
			PH_CHECK: begin
				r.status    = (frame_sum == b) ? ST_GOOD : ST_BADSUM;
				parse_phase = PH_HUNT;
			end
			default: parse_phase = PH_HUNT;
		endcase
		r.frame_id     = id_acc;
		r.frame_length = len_acc;
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			cfg_shadow.sync_byte   = SYNC_BYTE_RST;
			cfg_shadow.id_limit    = ID_LIMIT_RST;
			cfg_shadow.two_byte_id = 1'b0;
			parse_phase   = PH_HUNT;
			frame_sum     = '0;
			id_acc        = '0;
			len_acc       = '0;
			payload_count = '0;
			id_high_due   = 1'b0;
			expected_status_q.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_SYNC_BYTE:   cfg_shadow.sync_byte   = cfg_data;
					CFG_ID_LIMIT:    cfg_shadow.id_limit    = cfg_data;
					CFG_TWO_BYTE_ID: cfg_shadow.two_byte_id = cfg_data[0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (expected_status_q.size() == 0) begin
					$error("status result arrived with no byte waiting for one");
					fail_count++;
				end else begin
					want = expected_status_q.pop_front();
					check_field("status", 16'(want.status), 16'(m_tuser));
					check_field("payload_byte", 16'(want.payload_byte), 16'(m_tdata[7:0]));
					check_field("payload_index", 16'(want.payload_index),
						16'(m_tdata[15:8]));
					check_field("frame_id", want.frame_id, m_tdata[31:16]);
					check_field("frame_length", 16'(want.frame_length),
						16'(m_tdata[39:32]));
				end
			end
			if (s_tvalid && s_tready) begin
				advance_parser(s_tdata, want);
				expected_status_q.push_back(want);
			end
		end
		pending_count = expected_status_q.size();
	end

endmodule

[verif/sync_len_sum_frame_receiver_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_len_sum_frame_receiver_top_tb
// drives byte streams of sync / id / length / payload / check frames through
// the receiver under several register settings and idle patterns; the checker
// beside the block predicts every status result and counts mismatches
// ----------------------------------------------------------------------------
module sync_len_sum_frame_receiver_top_tb;
	import slfr_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [7:0]       s_tdata;   // [7:0] rx_byte
	logic             m_tvalid;
	logic             m_tready;
	logic [2:0]       m_tuser;   // [2:0] status
	logic [39:0]      m_tdata;   // [7:0] payload_byte, [15:8] payload_index,
	                             // [31:16] frame_id, [39:32] frame_length
	logic             cfg_wr_en;
	logic [1:0]       cfg_index;
	logic [ByteW-1:0] cfg_data;

	int fail_count;
	int pending_count;

	// idle pattern of the current phase, in percent
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	// register values as last written, used to build frames
	logic [7:0] cur_sync;
	logic [7:0] cur_limit;
	logic       cur_two;

	int unsigned sent_count;

	sync_len_sum_frame_receiver_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sync_len_sum_frame_receiver_checker result_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tuser       (m_tuser),
		.m_tdata       (m_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// receiver side: random stall per cycle at the phase's rate
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// one byte request; random idle cycles ahead of it, then hold until taken
	// valid is only ever assigned once per clock edge
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent_count++;
	endtask

	// a whole frame under the current settings; a rejected id still sends the
	// rest, which the block then sees while hunting
	task automatic send_frame(input logic [15:0] id, input logic [7:0] len,
		input bit spoil_sum);
		logic [7:0] sum;
		logic [7:0] pb;
		logic [7:0] chk;
		sum = cur_sync;
		send_byte(cur_sync);
		send_byte(id[7:0]);
		sum = sum + id[7:0];
		if (cur_two) begin
			send_byte(id[15:8]);
			sum = sum + id[15:8];
		end
		send_byte(len);
		sum = sum + len;
		for (int i = 0; i < len; i++) begin
			pb = 8'($urandom);
			send_byte(pb);
			sum = sum + pb;
		end
		chk = spoil_sum ? 8'(sum + $urandom_range(255, 1)) : sum;
		send_byte(chk);
	endtask

	// mostly short payloads, a few medium, rarely the full 255
	function automatic logic [7:0] pick_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 2)
			return 8'd255;
		if (r < 10)
			return 8'($urandom_range(64, 9));
		return 8'($urandom_range(8, 0));
	endfunction

	// random traffic: mostly well-formed frames, some line noise and some
	// frames cut off after a few bytes
	task automatic run_random(input int unsigned quota);
		int unsigned stop_at;
		int unsigned pick;
		logic [15:0] id;
		stop_at = sent_count + quota;
		while (sent_count < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				id = 16'($urandom);
				// one-byte mode: keep most ids under the limit so frames get through
				if (!cur_two && cur_limit != 8'd0 && $urandom_range(99) < 85)
					id[7:0] = 8'($urandom_range(cur_limit - 8'd1));
				send_frame(id, pick_length(), $urandom_range(99) < 15);
			end else if (pick < 85) begin
				repeat ($urandom_range(4, 1))
					send_byte(8'($urandom));
			end else begin
				send_byte(cur_sync);
				repeat ($urandom_range(3, 1))
					send_byte(8'($urandom));
			end
		end
	endtask

	// stop sending and wait until every status result has come back
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (pending_count != 0);
		repeat (3) @(posedge clk);
	endtask

	// write all three registers back to back while the block is idle
	task automatic configure(input logic [7:0] sync_v, input logic [7:0] limit_v,
		input logic two_v);
		logic [6:0] junk;
		junk      = 7'($urandom);
		cur_sync  = sync_v;
		cur_limit = limit_v;
		cur_two   = two_v;
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_SYNC_BYTE;
		cfg_data  <= sync_v;
		@(posedge clk);
		cfg_index <= CFG_ID_LIMIT;
		cfg_data  <= limit_v;
		@(posedge clk);
		// only bit 0 counts for the mode flag, upper bits are random
		cfg_index <= CFG_TWO_BYTE_ID;
		cfg_data  <= {junk, two_v};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		m_tready       = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = CFG_SYNC_BYTE;
		cfg_data       = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		sent_count     = 0;
		cur_sync       = SYNC_BYTE_RST;
		cur_limit      = ID_LIMIT_RST;
		cur_two        = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, no idling: noise at both byte extremes, empty frame,
		// id just under the limit, id at the limit, spoiled checksum
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(16'h0000, 8'd0, 1'b0);
		send_frame(16'h00FE, 8'd2, 1'b0);
		send_frame(16'h00FF, 8'd0, 1'b0);
		send_frame(16'h0007, 8'd1, 1'b1);
		run_random(300);
		wait_results_drained();

		// sync 0x00 and limit 0: every one-byte id is turned away
		configure(8'h00, 8'h00, 1'b0);
		send_idle_pct = 65;
		send_frame(16'h0000, 8'd1, 1'b0);
		run_random(300);
		wait_results_drained();

		// two-byte ids with sync 0xFF, receiver stalling
		configure(8'hFF, 8'hFF, 1'b1);
		send_idle_pct  = 0;
		recv_stall_pct = 65;
		send_frame(16'hFFFF, 8'd3, 1'b0);
		send_frame(16'h0000, 8'd0, 1'b0);
		run_random(300);
		// try to leave the parser waiting for the high id byte
		send_byte(cur_sync);
		send_byte(8'h5A);
		wait_results_drained();

		// back to one-byte mode while the high id byte may still be due
		configure(8'($urandom), 8'($urandom), 1'b0);
		send_idle_pct  = 33;
		recv_stall_pct = 33;
		run_random(300);
		wait_results_drained();

		configure(8'($urandom), 8'($urandom), 1'b1);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random(300);
		wait_results_drained();

		configure(8'hAA, 8'h80, 1'b0);
		send_idle_pct  = 33;
		recv_stall_pct = 33;
		run_random(300);
		wait_results_drained();

		repeat (5) @(posedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/slfr_pkg.sv
rtl/core/slfr_parser.sv
rtl/core/slfr_out_reg.sv
rtl/core/sync_len_sum_frame_receiver_top.sv
verif/sync_len_sum_frame_receiver_checker.sv
verif/sync_len_sum_frame_receiver_top_tb.sv
